FILE: src/lsfe_pkg.sv
// Shared types and constants for the LSB stego frame extractor.
package lsfe_pkg;

    localparam int HEADER_BYTES_DEF = 54;
    localparam int EXT_MAX_DEF      = 9;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 64;
    localparam int MAGIC_W    = 64;
    localparam int MLEN_W     = 4;
    localparam int EXT_LEN_W  = 4;
    localparam int ACC_W      = 32;
    localparam int POS_W      = 5;
    localparam int LEFT_W     = 31;

    localparam logic [MAGIC_W-1:0] MAGIC_WORD_RST = MAGIC_W'(10787);
    localparam logic [MLEN_W-1:0]  MAGIC_LEN_RST  = MLEN_W'(2);
    localparam logic [MLEN_W-1:0]  MAGIC_LEN_MIN  = MLEN_W'(1);
    localparam logic [MLEN_W-1:0]  MAGIC_LEN_MAX  = MLEN_W'(8);

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_MAGIC_WORD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAGIC_LEN  = 1'b1;

    typedef enum logic [2:0] {
        KIND_EXT_CHAR  = 3'd0,
        KIND_PAY_BYTE  = 3'd1,
        KIND_EXT_LEN   = 3'd2,
        KIND_PAY_SIZE  = 3'd3,
        KIND_MAGIC_BAD = 3'd4,
        KIND_EXT_LONG  = 3'd5
    } kind_t;

    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_MAGIC   = 7'b0000010,
        PH_EXTLEN  = 7'b0000100,
        PH_EXTCHR  = 7'b0001000,
        PH_PAYSIZE = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_HALT    = 7'b1000000
    } phase_t;

    // Bit gather step result.
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [POS_W-1:0] pos;
        logic             done;
        logic [ACC_W-1:0] value;
    } gather_t;

endpackage

FILE: src/lsb_stego_frame_extractor.sv
// Top level: BMP LSB steganography message extractor.
// Results are registered: each shows on m_ in the cycle after the byte that ends its field.
// Throughput: one byte per cycle; a byte is taken whenever the result register is empty
// or is being drained in the same cycle.
// Reset: aresetn low (synchronous) returns to header skip, clears counters and the result
// valid, and restores magic_word to "#*" and magic_length to 2.
module lsb_stego_frame_extractor #(
    parameter int HEADER_BYTES = lsfe_pkg::HEADER_BYTES_DEF,
    parameter int EXT_MAX      = lsfe_pkg::EXT_MAX_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lsfe_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lsfe_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_pixel_byte,
    input  logic                            s_start_of_image,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_data_byte,
    output logic [31:0]                     m_size_value,
    output logic [2:0]                      m_result_kind,
    output logic                            m_last_of_message
);

    // Field counter must hold the header length and any magic / extension count.
    localparam int HB_W = $clog2(HEADER_BYTES + 1);
    localparam int FC_W = (HB_W > 4) ? HB_W : 4;

    // Configuration registers
    logic [lsfe_pkg::MAGIC_W-1:0] magic_word_reg;
    logic [lsfe_pkg::MLEN_W-1:0]  magic_len_reg;

    // Parse state
    lsfe_pkg::phase_t                 phase_reg, phase_next;
    logic [lsfe_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [lsfe_pkg::ACC_W-1:0]       acc_reg, acc_next;
    logic [FC_W-1:0]                  fc_reg, fc_next;
    logic [lsfe_pkg::EXT_LEN_W-1:0]   ext_len_reg, ext_len_next;
    logic [lsfe_pkg::LEFT_W-1:0]      left_reg, left_next;

    // Result register
    logic        m_valid_reg;
    logic [7:0]  data_reg, data_next;
    logic [31:0] size_reg, size_next;
    logic [2:0]  kind_reg, kind_next;
    logic        last_reg, last_next;
    logic        emit;

    // Effective state once a start of image has been applied
    lsfe_pkg::phase_t               ph_eff;
    logic [lsfe_pkg::POS_W-1:0]     pos_eff;
    logic [lsfe_pkg::ACC_W-1:0]     acc_eff;
    logic [FC_W-1:0]                fc_eff;
    logic [FC_W-1:0]                fc_inc;
    logic [lsfe_pkg::MLEN_W-1:0]    magic_cnt;
    logic [7:0]                     magic_expect;
    logic [lsfe_pkg::LEFT_W-1:0]    left_dec;
    logic                           in_header;
    logic                           wide_field;
    lsfe_pkg::gather_t              gstep;

    logic s_fire;

    // Take a new request whenever the result slot is free or draining now.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign m_valid           = m_valid_reg;
    assign m_data_byte       = data_reg;
    assign m_size_value      = size_reg;
    assign m_result_kind     = kind_reg;
    assign m_last_of_message = last_reg;

    // Start of image restarts the parse on this very byte.
    always_comb begin
        ph_eff  = s_start_of_image ? lsfe_pkg::PH_HEADER : phase_reg;
        pos_eff = s_start_of_image ? '0 : pos_reg;
        acc_eff = s_start_of_image ? '0 : acc_reg;
        fc_eff  = s_start_of_image ? '0 : fc_reg;
    end

    // Still inside the header: the byte is skipped with no bit gathered.
    assign in_header  = (ph_eff == lsfe_pkg::PH_HEADER) && (fc_eff < FC_W'(HEADER_BYTES));
    assign wide_field = (ph_eff == lsfe_pkg::PH_EXTLEN) || (ph_eff == lsfe_pkg::PH_PAYSIZE);

    lsfe_gather u_gather (
        .acc_in     (acc_eff),
        .pos_in     (pos_eff),
        .bit_in     (s_pixel_byte[0]),
        .wide_field (wide_field),
        .step       (gstep)
    );

    // Clamp the magic length into 1..8.
    always_comb begin
        if (magic_len_reg == '0) begin
            magic_cnt = lsfe_pkg::MAGIC_LEN_MIN;
        end else if (magic_len_reg > lsfe_pkg::MAGIC_LEN_MAX) begin
            magic_cnt = lsfe_pkg::MAGIC_LEN_MAX;
        end else begin
            magic_cnt = magic_len_reg;
        end
    end

    // A header byte past the end is the first magic bit, so the counter restarts at zero.
    logic [FC_W-1:0] fc_work;
    assign fc_work      = (ph_eff == lsfe_pkg::PH_HEADER) ? '0 : fc_eff;
    assign fc_inc       = fc_work + FC_W'(1);
    assign magic_expect = magic_word_reg[{fc_work[2:0], 3'b000} +: 8];
    assign left_dec     = (left_reg != '0) ? left_reg - lsfe_pkg::LEFT_W'(1) : left_reg;

    always_comb begin
        phase_next   = ph_eff;
        pos_next     = pos_eff;
        acc_next     = acc_eff;
        fc_next      = fc_eff;
        ext_len_next = s_start_of_image ? '0 : ext_len_reg;
        left_next    = s_start_of_image ? '0 : left_reg;
        emit         = 1'b0;
        data_next    = '0;
        size_next    = '0;
        kind_next    = lsfe_pkg::KIND_EXT_CHAR;
        last_next    = 1'b0;

        if (in_header) begin
            fc_next = fc_eff + FC_W'(1);
        end else if (ph_eff != lsfe_pkg::PH_HALT) begin
            pos_next = gstep.pos;
            acc_next = gstep.acc;
            fc_next  = fc_work;
            if (gstep.done) begin
                case (ph_eff)
                    lsfe_pkg::PH_HEADER,
                    lsfe_pkg::PH_MAGIC: begin
                        if (gstep.value[7:0] != magic_expect) begin
                            // mismatch: report the bad character and halt
                            phase_next = lsfe_pkg::PH_HALT;
                            emit       = 1'b1;
                            data_next  = gstep.value[7:0];
                            kind_next  = lsfe_pkg::KIND_MAGIC_BAD;
                        end else if (fc_inc >= FC_W'(magic_cnt)) begin
                            fc_next    = '0;
                            phase_next = lsfe_pkg::PH_EXTLEN;
                        end else begin
                            fc_next    = fc_inc;
                            phase_next = lsfe_pkg::PH_MAGIC;
                        end
                    end
                    lsfe_pkg::PH_EXTLEN: begin
                        emit      = 1'b1;
                        size_next = gstep.value;
                        fc_next   = '0;
                        if (gstep.value[31]) begin
                            ext_len_next = '0;
                            phase_next   = lsfe_pkg::PH_PAYSIZE;
                            kind_next    = lsfe_pkg::KIND_EXT_LEN;
                        end else if (gstep.value > 32'(EXT_MAX)) begin
                            phase_next = lsfe_pkg::PH_HALT;
                            kind_next  = lsfe_pkg::KIND_EXT_LONG;
                        end else begin
                            ext_len_next = gstep.value[lsfe_pkg::EXT_LEN_W-1:0];
                            phase_next   = (gstep.value[lsfe_pkg::EXT_LEN_W-1:0] == '0)
                                           ? lsfe_pkg::PH_PAYSIZE : lsfe_pkg::PH_EXTCHR;
                            kind_next    = lsfe_pkg::KIND_EXT_LEN;
                        end
                    end
                    lsfe_pkg::PH_EXTCHR: begin
                        emit      = 1'b1;
                        data_next = gstep.value[7:0];
                        kind_next = lsfe_pkg::KIND_EXT_CHAR;
                        if (fc_inc >= FC_W'(ext_len_reg)) begin
                            fc_next    = '0;
                            phase_next = lsfe_pkg::PH_PAYSIZE;
                        end else begin
                            fc_next = fc_inc;
                        end
                    end
                    lsfe_pkg::PH_PAYSIZE: begin
                        emit      = 1'b1;
                        size_next = gstep.value;
                        kind_next = lsfe_pkg::KIND_PAY_SIZE;
                        if (gstep.value[31] || (gstep.value == '0)) begin
                            // empty payload ends the message here
                            left_next  = '0;
                            phase_next = lsfe_pkg::PH_HALT;
                            last_next  = 1'b1;
                        end else begin
                            left_next  = gstep.value[lsfe_pkg::LEFT_W-1:0];
                            phase_next = lsfe_pkg::PH_PAYLOAD;
                        end
                    end
                    lsfe_pkg::PH_PAYLOAD: begin
                        emit      = 1'b1;
                        data_next = gstep.value[7:0];
                        kind_next = lsfe_pkg::KIND_PAY_BYTE;
                        left_next = left_dec;
                        if (left_dec == '0) begin
                            last_next  = 1'b1;
                            phase_next = lsfe_pkg::PH_HALT;
                        end
                    end
                    default: begin
                        phase_next = lsfe_pkg::PH_HALT;
                    end
                endcase
            end else if (ph_eff == lsfe_pkg::PH_HEADER) begin
                // header done mid-field: move into magic gathering
                phase_next = lsfe_pkg::PH_MAGIC;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_word_reg <= lsfe_pkg::MAGIC_WORD_RST;
            magic_len_reg  <= lsfe_pkg::MAGIC_LEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lsfe_pkg::REG_MAGIC_WORD: magic_word_reg <= cfg_wdata;
                lsfe_pkg::REG_MAGIC_LEN:  magic_len_reg  <= cfg_wdata[lsfe_pkg::MLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Parse state: advance only on an accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= lsfe_pkg::PH_HEADER;
            pos_reg     <= '0;
            acc_reg     <= '0;
            fc_reg      <= '0;
            ext_len_reg <= '0;
            left_reg    <= '0;
        end else if (s_fire) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            fc_reg      <= fc_next;
            ext_len_reg <= ext_len_next;
            left_reg    <= left_next;
        end
    end

    // Result register: load on a producing request, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            data_reg <= data_next;
            size_reg <= size_next;
            kind_reg <= kind_next;
            last_reg <= last_next;
        end
    end

endmodule

FILE: src/lsfe_gather.sv
// Bit gather: insert one LSB-first bit into the field accumulator.
module lsfe_gather (
    input  logic [lsfe_pkg::ACC_W-1:0] acc_in,
    input  logic [lsfe_pkg::POS_W-1:0] pos_in,
    input  logic                       bit_in,
    input  logic                       wide_field,
    output lsfe_pkg::gather_t          step
);

    logic [lsfe_pkg::ACC_W-1:0] acc_ins;
    logic                       last_bit;

    always_comb begin
        acc_ins  = acc_in;
        acc_ins[pos_in] = acc_in[pos_in] | bit_in;
        // narrow fields end at bit 7, wide ones at bit 31
        last_bit = wide_field ? (pos_in == lsfe_pkg::POS_W'(31))
                              : (pos_in == lsfe_pkg::POS_W'(7));
        step.value = acc_ins;
        step.done  = last_bit;
        step.acc   = last_bit ? '0 : acc_ins;
        step.pos   = last_bit ? '0 : pos_in + lsfe_pkg::POS_W'(1);
    end

endmodule

FILE: src/lsfe_checker.sv
// Port-level checker for the stego extractor, bound to the top level.
module lsfe_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            cfg_wr_en,
    input logic [lsfe_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input logic [lsfe_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [7:0]                      s_pixel_byte,
    input logic                            s_start_of_image,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [7:0]                      m_data_byte,
    input logic [31:0]                     m_size_value,
    input logic [2:0]                      m_result_kind,
    input logic                            m_last_of_message
);

    // An empty result slot never blocks the input side.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty result slot");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_kind <= 3'(lsfe_pkg::KIND_EXT_LONG)))
        else $error("undefined result kind");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_message) |->
            (m_result_kind == 3'(lsfe_pkg::KIND_PAY_BYTE) ||
             m_result_kind == 3'(lsfe_pkg::KIND_PAY_SIZE)))
        else $error("last flag on a non-payload result");

    a_size_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == 3'(lsfe_pkg::KIND_EXT_CHAR) ||
                     m_result_kind == 3'(lsfe_pkg::KIND_PAY_BYTE) ||
                     m_result_kind == 3'(lsfe_pkg::KIND_MAGIC_BAD))) |->
            (m_size_value == '0))
        else $error("size value set on a character result");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data_byte) &&
            $stable(m_size_value) && $stable(m_result_kind) && $stable(m_last_of_message)))
        else $error("stalled result changed");

endmodule

bind lsb_stego_frame_extractor lsfe_checker u_lsfe_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the LSB stego extractor: BMP-like streams against a predictor.
module tb;

    localparam int HDR_LEN      = lsfe_pkg::HEADER_BYTES_DEF;
    localparam int EXT_LIMIT    = lsfe_pkg::EXT_MAX_DEF;
    localparam int QUIET_LIMIT  = 3000;  // cycles with no request or report moving
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off that backs up the block
    localparam int DRAIN_CYCLES = 4;     // a result is registered and shows in the cycle after its last byte

    // One image byte as offered on the request side.
    typedef struct packed {
        logic [7:0] pix;
        logic       soi;
    } image_byte_t;

    // One decoded report as it should leave the block.
    typedef struct packed {
        logic [7:0]      data;
        logic [31:0]     size;
        lsfe_pkg::kind_t kind;
        logic            is_last;
    } stego_report_t;

    logic                            aclk             = 1'b0;
    logic                            aresetn          = 1'b0;
    logic                            cfg_wr_en        = 1'b0;
    logic [lsfe_pkg::CFG_ADDR_W-1:0] cfg_addr         = '0;
    logic [lsfe_pkg::CFG_DATA_W-1:0] cfg_wdata        = '0;
    logic                            s_valid          = 1'b0;
    logic                            s_ready;
    logic [7:0]                      s_pixel_byte     = '0;
    logic                            s_start_of_image = 1'b0;
    logic                            m_valid;
    logic                            m_ready          = 1'b0;
    logic [7:0]                      m_data_byte;
    logic [31:0]                     m_size_value;
    logic [2:0]                      m_result_kind;
    logic                            m_last_of_message;

    lsb_stego_frame_extractor DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pixel_byte      (s_pixel_byte),
        .s_start_of_image  (s_start_of_image),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data_byte       (m_data_byte),
        .m_size_value      (m_size_value),
        .m_result_kind     (m_result_kind),
        .m_last_of_message (m_last_of_message)
    );

    // Bytes waiting to be offered, and reports the predictor says must come out.
    image_byte_t   image_q[$];
    stego_report_t report_q[$];

    int   err_cnt    = 0;
    int   quiet_cnt  = 0;
    int   burst_odds = 0;  // 1-in-N chance to start an idle burst; 0 means no idling
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;
    int   hold_cnt   = 0;
    int   src_gap    = 0;
    int   snk_gap    = 0;
    logic in_take    = 1'b0;

    // Register values as last written, used to shape the generated frames.
    logic [lsfe_pkg::MAGIC_W-1:0] gen_magic = lsfe_pkg::MAGIC_WORD_RST;
    logic [lsfe_pkg::MLEN_W-1:0]  gen_mlen  = lsfe_pkg::MAGIC_LEN_RST;

    // Predictor copy of the configuration and of the parse state.
    logic [lsfe_pkg::MAGIC_W-1:0]   pred_magic;
    logic [lsfe_pkg::MLEN_W-1:0]    pred_mlen;
    lsfe_pkg::phase_t               ph;
    logic [lsfe_pkg::POS_W-1:0]     shift_pos;
    logic [lsfe_pkg::ACC_W-1:0]     shift_acc;
    logic [31:0]                    fcnt;
    logic [lsfe_pkg::EXT_LEN_W-1:0] ext_len;
    logic [lsfe_pkg::LEFT_W-1:0]    pay_left;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp the magic length register to the number of characters checked.
    function automatic int magic_chars(input logic [lsfe_pkg::MLEN_W-1:0] mlen);
        if (mlen == 0)
            return 1;
        if (mlen > 8)
            return 8;
        return int'(mlen);
    endfunction

    function automatic void restart_parse();
        ph        = lsfe_pkg::PH_HEADER;
        shift_pos = '0;
        shift_acc = '0;
        fcnt      = '0;
        ext_len   = '0;
        pay_left  = '0;
    endfunction

    // Shift one hidden bit in, LSB first; return 1 with the word once nbits are in.
    function automatic logic take_bit(input logic b, input logic [5:0] nbits,
                                      output logic [31:0] word);
        shift_acc[shift_pos] = b;
        shift_pos            = shift_pos + 1'b1;
        word                 = shift_acc;
        if (shift_pos == nbits[4:0]) begin
            shift_acc = '0;
            shift_pos = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void store_report(input logic [7:0] data, input logic [31:0] size,
                                         input lsfe_pkg::kind_t kind, input logic is_last);
        stego_report_t r;
        r.data    = data;
        r.size    = size;
        r.kind    = kind;
        r.is_last = is_last;
        report_q.push_back(r);
    endfunction

    // Advance the parse by one accepted image byte and queue any report it causes.
    function automatic void decode_image_byte(input logic [7:0] pix, input logic soi);
        logic [31:0] word;
        logic [7:0]  want_ch;
        logic        is_last;
        if (soi)
            restart_parse();
        if (ph == lsfe_pkg::PH_HEADER && fcnt < HDR_LEN) begin
            fcnt = fcnt + 1;
        end else begin
            if (ph == lsfe_pkg::PH_HEADER) begin
                ph   = lsfe_pkg::PH_MAGIC;
                fcnt = '0;
            end
            case (ph)
                lsfe_pkg::PH_MAGIC: begin
                    if (take_bit(pix[0], 6'd8, word)) begin
                        want_ch = 8'(pred_magic >> {fcnt[2:0], 3'b000});
                        if (word[7:0] != want_ch) begin
                            ph = lsfe_pkg::PH_HALT;
                            store_report(word[7:0], 32'd0, lsfe_pkg::KIND_MAGIC_BAD, 1'b0);
                        end else begin
                            fcnt = fcnt + 1;
                            if (fcnt >= magic_chars(pred_mlen)) begin
                                fcnt = '0;
                                ph   = lsfe_pkg::PH_EXTLEN;
                            end
                        end
                    end
                end
                lsfe_pkg::PH_EXTLEN: begin
                    if (take_bit(pix[0], 6'd32, word)) begin
                        if (!word[31] && word > EXT_LIMIT) begin
                            ph = lsfe_pkg::PH_HALT;
                            store_report(8'd0, word, lsfe_pkg::KIND_EXT_LONG, 1'b0);
                        end else begin
                            // A negative length means no extension characters at all.
                            ext_len = word[31] ? '0 : word[lsfe_pkg::EXT_LEN_W-1:0];
                            fcnt    = '0;
                            ph      = (ext_len == 0) ? lsfe_pkg::PH_PAYSIZE
                                                     : lsfe_pkg::PH_EXTCHR;
                            store_report(8'd0, word, lsfe_pkg::KIND_EXT_LEN, 1'b0);
                        end
                    end
                end
                lsfe_pkg::PH_EXTCHR: begin
                    if (take_bit(pix[0], 6'd8, word)) begin
                        fcnt = fcnt + 1;
                        if (fcnt >= ext_len) begin
                            fcnt = '0;
                            ph   = lsfe_pkg::PH_PAYSIZE;
                        end
                        store_report(word[7:0], 32'd0, lsfe_pkg::KIND_EXT_CHAR, 1'b0);
                    end
                end
                lsfe_pkg::PH_PAYSIZE: begin
                    if (take_bit(pix[0], 6'd32, word)) begin
                        if (word[31] || word == 0) begin
                            pay_left = '0;
                            ph       = lsfe_pkg::PH_HALT;
                            store_report(8'd0, word, lsfe_pkg::KIND_PAY_SIZE, 1'b1);
                        end else begin
                            pay_left = word[lsfe_pkg::LEFT_W-1:0];
                            ph       = lsfe_pkg::PH_PAYLOAD;
                            store_report(8'd0, word, lsfe_pkg::KIND_PAY_SIZE, 1'b0);
                        end
                    end
                end
                lsfe_pkg::PH_PAYLOAD: begin
                    if (take_bit(pix[0], 6'd8, word)) begin
                        if (pay_left > 0)
                            pay_left = pay_left - 1'b1;
                        is_last = (pay_left == 0);
                        if (is_last)
                            ph = lsfe_pkg::PH_HALT;
                        store_report(word[7:0], 32'd0, lsfe_pkg::KIND_PAY_BYTE, is_last);
                    end
                end
                default: begin
                    // Halted: drop bytes until the next start of image.
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Frame generation
    // ------------------------------------------------------------------

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void push_byte(input logic [7:0] pix, input logic soi);
        image_byte_t it;
        it.pix = pix;
        it.soi = soi;
        image_q.push_back(it);
    endfunction

    // Hide a value LSB first in the low bits of random bytes.
    function automatic void push_bits(input logic [31:0] val, input int nbits);
        for (int i = 0; i < nbits; i++)
            push_byte({7'($urandom), val[i]}, 1'b0);
    endfunction

    // Build one image: header, magic (optionally spoiled at char bad_at), extension
    // length and characters, payload size and n_pay payload bytes. Stop where the
    // block would halt.
    function automatic void push_frame(input int bad_at, input logic [31:0] ext_word,
                                       input logic [31:0] size_word, input int n_pay);
        int         m;
        int         n_ext;
        logic [7:0] ch;
        m = magic_chars(gen_mlen);
        for (int i = 0; i < HDR_LEN; i++)
            push_byte(8'($urandom), i == 0);
        for (int i = 0; i < m && (bad_at < 0 || i <= bad_at); i++) begin
            ch = 8'(gen_magic >> (8 * i));
            if (i == bad_at)
                ch = ch ^ 8'($urandom_range(1, 255));
            push_bits(32'(ch), 8);
        end
        if (bad_at < 0 || bad_at >= m) begin
            push_bits(ext_word, 32);
            if (ext_word[31] || ext_word <= EXT_LIMIT) begin
                n_ext = ext_word[31] ? 0 : int'(ext_word);
                for (int i = 0; i < n_ext; i++)
                    push_bits(32'(pick_char()), 8);
                push_bits(size_word, 32);
                for (int i = 0; i < n_pay; i++)
                    push_bits(32'(pick_char()), 8);
            end
        end
    endfunction

    // Mostly well-formed frames with random content; the rest are broken on purpose.
    function automatic void push_random_frame();
        int          pick;
        int          n_pay;
        int          start;
        int          cut;
        logic [31:0] ext_w;
        logic [31:0] size_w;
        pick   = $urandom_range(0, 99);
        ext_w  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, EXT_LIMIT)
                                             : $urandom_range(0, 3);
        size_w = $urandom_range(1, 6);
        n_pay  = int'(size_w);
        if ($urandom_range(0, 11) == 0) begin
            // Huge size: the payload runs on until the next start of image.
            size_w = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : {1'b0, 31'($urandom)};
            n_pay  = $urandom_range(0, 6);
        end
        start = image_q.size();
        if (pick < 70) begin
            push_frame(-1, ext_w, size_w, n_pay);
        end else if (pick < 77) begin
            push_frame($urandom_range(0, magic_chars(gen_mlen) - 1), ext_w, size_w, n_pay);
        end else if (pick < 83) begin
            push_frame(-1, ($urandom_range(0, 1) == 0) ? 32'(EXT_LIMIT + 1)
                           : $urandom_range(EXT_LIMIT + 1, 32'h7FFF_FFFF), size_w, n_pay);
        end else if (pick < 89) begin
            push_frame(-1, {1'b1, 31'($urandom)}, size_w, n_pay);
        end else if (pick < 94) begin
            push_frame(-1, ext_w, ($urandom_range(0, 1) == 0) ? 32'd0
                                  : {1'b1, 31'($urandom)}, 0);
        end else begin
            // Truncate: the next start of image must restart the parse cleanly.
            push_frame(-1, ext_w, size_w, n_pay);
            cut = $urandom_range(start + 1, image_q.size() - 1);
            while (image_q.size() > cut)
                image_q.delete(image_q.size() - 1);
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4))
                push_byte(8'($urandom), $urandom_range(0, 15) == 0);
        end
    endfunction

    // ------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------

    // Wait until every byte is in and every predicted report is out, then
    // let the block settle.
    task automatic drain();
        logic idle;
        idle = 1'b0;
        while (!idle) begin
            @(posedge aclk);
            if (image_q.size() == 0 && !s_valid) begin
                @(negedge aclk);
                idle = (report_q.size() == 0);
            end
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_regs(input logic [lsfe_pkg::MAGIC_W-1:0] word,
                              input logic [lsfe_pkg::MLEN_W-1:0] mlen);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= lsfe_pkg::REG_MAGIC_WORD;
        cfg_wdata <= word;
        @(negedge aclk);
        cfg_addr  <= lsfe_pkg::REG_MAGIC_LEN;
        // Upper bits are don't-care for the length register; keep them noisy.
        cfg_wdata <= {(lsfe_pkg::CFG_DATA_W - lsfe_pkg::MLEN_W)'({$urandom, $urandom}),
                      mlen};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        gen_magic = word;
        gen_mlen  = mlen;
    endtask

    // Reconfigure while idle, then queue a batch of random frames.
    task automatic run_phase(input logic [lsfe_pkg::MAGIC_W-1:0] word,
                             input logic [lsfe_pkg::MLEN_W-1:0] mlen,
                             input int odds, input int budget, input logic squeeze);
        drain();
        write_regs(word, mlen);
        @(posedge aclk);
        burst_odds <= odds;
        if (squeeze)
            hold_req <= 1'b1;
        while (image_q.size() < budget)
            push_random_frame();
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_odds <= 8;

        // Directed frames under the reset magic "#*", two characters.
        push_frame(-1, 32'd2, 32'd3, 3);                 // clean message
        push_frame(0, 32'd1, 32'd1, 1);                  // first magic char wrong
        push_bits(32'hFFFF_FFFF, 24);                    // then dropped while halted
        push_frame(1, 32'd1, 32'd1, 1);                  // last magic char wrong
        push_frame(-1, 32'h8000_0005, 32'd0, 0);         // negative ext length, empty payload
        push_frame(-1, 32'(EXT_LIMIT + 1), 32'd1, 1);    // extension just too long
        push_frame(-1, 32'(EXT_LIMIT), 32'hFFFF_FFFF, 0); // longest extension, negative size
        push_frame(-1, 32'd0, 32'd1, 1);                 // no extension, single payload byte
        push_bits(32'h0000_0000, 8);
        push_bits(32'h0000_00FF, 8);
        push_frame(-1, 32'd1, 32'd5, 5);                 // cut short mid-payload
        repeat (20) image_q.delete(image_q.size() - 1);

        // Random phases, sweeping the registers through their extremes.
        run_phase('1, 4'd15, 4, 1, 1'b0);
        run_phase('0, 4'd0, 12, 1, 1'b0);
        run_phase({$urandom, $urandom}, 4'($urandom_range(1, 8)), 0, 1, 1'b1);
        run_phase({$urandom, $urandom}, 4'($urandom_range(1, 8)), 0, 1, 1'b0);

        drain();
        repeat (8) @(negedge aclk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver: advance on acceptance, insert random idle bursts.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        image_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_take) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (image_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (burst_odds != 0 && $urandom_range(1, burst_odds) == 1) begin
                src_gap <= $urandom_range(0, 16);
                s_valid <= 1'b0;
            end else begin
                nxt = image_q.pop_front();
                s_valid          <= 1'b1;
                s_pixel_byte     <= nxt.pix;
                s_start_of_image <= nxt.soi;
            end
        end
    end

    // ------------------------------------------------------------------
    // Report receiver: one long hold-off on request, else random stalls.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_cnt  <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            m_ready <= 1'b0;
        end else if (burst_odds != 0 && $urandom_range(1, burst_odds) == 1) begin
            snk_gap <= $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: track register writes, predict on each accepted request,
    // check each accepted report against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        if (err_cnt < 100)
            $display("%0t ns: MISMATCH %s", $time, msg);
        err_cnt++;
    endtask

    always @(posedge aclk) begin
        stego_report_t want;
        in_take <= aresetn && s_valid && s_ready;
        if (!aresetn) begin
            pred_magic = lsfe_pkg::MAGIC_WORD_RST;
            pred_mlen  = lsfe_pkg::MAGIC_LEN_RST;
            restart_parse();
            report_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == lsfe_pkg::REG_MAGIC_WORD)
                    pred_magic = cfg_wdata[lsfe_pkg::MAGIC_W-1:0];
                else if (cfg_addr == lsfe_pkg::REG_MAGIC_LEN)
                    pred_mlen = cfg_wdata[lsfe_pkg::MLEN_W-1:0];
            end
            // Check before predicting: a report never leaves on its own byte's edge.
            if (m_valid && m_ready) begin
                if (report_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected report kind %0d size %h data %h",
                                            m_result_kind, m_size_value, m_data_byte));
                end else begin
                    want = report_q.pop_front();
                    if (m_result_kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, want %0d",
                                                m_result_kind, want.kind));
                    if (m_data_byte !== want.data)
                        flag_mismatch($sformatf("data_byte %h, want %h (kind %0d)",
                                                m_data_byte, want.data, want.kind));
                    if (m_size_value !== want.size)
                        flag_mismatch($sformatf("size_value %h, want %h (kind %0d)",
                                                m_size_value, want.size, want.kind));
                    if (m_last_of_message !== want.is_last)
                        flag_mismatch($sformatf("last_of_message %b, want %b (kind %0d)",
                                                m_last_of_message, want.is_last, want.kind));
                end
            end
            if (s_valid && s_ready)
                decode_image_byte(s_pixel_byte, s_start_of_image);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

endmodule
